// ===== hw/rtl/hcc_pkg.sv =====
// Shared types and constants for the Hilbert curve index converter.
package hcc_pkg;

  localparam int MAX_ORDER = 16;
  localparam int ORDER_W = 5;
  localparam int COORD_W = 16;
  localparam int INDEX_W = 32;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

  typedef enum logic {
    OP_TO_INDEX = 1'b0,
    OP_TO_COORD = 1'b1
  } hcc_op_t;

  typedef struct packed {
    hcc_op_t            op;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [INDEX_W-1:0] curve_index;
  } hcc_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_result;
    logic [COORD_W-1:0] x_result;
    logic [COORD_W-1:0] y_result;
  } hcc_out_t;

  typedef struct packed {
    hcc_op_t            op;
    logic [ORDER_W-1:0] grid_order;
    logic               swp;
    logic               inv;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [INDEX_W-1:0] curve_index;
    logic [INDEX_W-1:0] index_result;
    logic [COORD_W-1:0] x_result;
    logic [COORD_W-1:0] y_result;
  } hcc_work_t;

endpackage

// ===== hw/rtl/hcc_stage.sv =====
// One pipeline stage that resolves a group of curve levels and registers the word.
module hcc_stage #(
  parameter int FIRST_LEVEL = 15,
  parameter int LEVELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  hcc_pkg::hcc_work_t up_work,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hcc_pkg::hcc_work_t dn_work
);
  import hcc_pkg::*;

  hcc_work_t work_c [0:LEVELS];
  logic      vld;
  hcc_work_t work;

  assign work_c[0] = up_work;

  for (genvar i = 0; i < LEVELS; i++) begin : g_level
    localparam int LVL = FIRST_LEVEL - i;
    if (LVL >= 0) begin : g_active
      logic a, c, qx, qy;
      hcc_work_t w;
      always_comb begin
        w = work_c[i];
        a = 1'b0;
        c = 1'b0;
        qx = 1'b0;
        qy = 1'b0;
        if (w.grid_order > ORDER_W'(LVL)) begin
          if (w.op == OP_TO_INDEX) begin
            a = (w.swp ? w.y_coord[LVL] : w.x_coord[LVL]) ^ w.inv;
            c = (w.swp ? w.x_coord[LVL] : w.y_coord[LVL]) ^ w.inv;
            w.index_result[2*LVL+1] = a;
            w.index_result[2*LVL] = a ^ c;
            if (!c) begin
              w.inv = w.inv ^ a;
              w.swp = ~w.swp;
            end
          end else begin
            qx = w.curve_index[2*LVL+1];
            qy = w.curve_index[2*LVL] ^ qx;
            w.x_result[LVL] = (w.swp ? qy : qx) ^ w.inv;
            w.y_result[LVL] = (w.swp ? qx : qy) ^ w.inv;
            if (!qy) begin
              w.inv = w.inv ^ qx;
              w.swp = ~w.swp;
            end
          end
        end
      end
      assign work_c[i+1] = w;
    end else begin : g_idle
      assign work_c[i+1] = work_c[i];
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work <= work_c[LEVELS];
    end
  end

  assign dn_valid = vld;
  assign dn_work = work;

endmodule

// ===== hw/rtl/hilbert_curve_convert.sv =====
// Top level of the Hilbert curve converter between grid coordinates and curve index.
// The input channel (in_valid, in_ready, in_word) takes one word per cycle while in_ready
// is high. op selects coordinate to index or index to coordinate; inputs are masked to the
// grid order. The output channel (out_valid, out_ready, out_word) returns one word per
// input word, in order; result fields that the op does not produce read zero.
// grid_order is written through cfg_we and cfg_data; the user must do so only while idle,
// the block does not enforce it; values above 16 act as 16 and zero gives all-zero results.
// The pipeline has NUM_STAGES stages, where NUM_STAGES = ceil(16 / STAGE_LEVELS), four at the
// default; each stage resolves STAGE_LEVELS quadrant levels, the most significant first.
// Throughput is one word per cycle while out_ready stays high.
// Each stage holds its word while the next one is full, so a stall on out_ready backs up
// stage by stage and in_ready falls only when every stage holds a word.
// Synchronous reset empties the pipeline and sets grid_order to 16.
module hilbert_curve_convert #(
  parameter int STAGE_LEVELS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hcc_pkg::hcc_in_t            in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hcc_pkg::hcc_out_t           out_word,
  input  logic                        cfg_we,
  input  logic [hcc_pkg::ORDER_W-1:0] cfg_data
);
  import hcc_pkg::*;

  localparam int NUM_STAGES = (MAX_ORDER + STAGE_LEVELS - 1) / STAGE_LEVELS;

  logic [ORDER_W-1:0] grid_order;
  logic [ORDER_W-1:0] eff_order;
  hcc_work_t          entry;
  logic               valid_c [0:NUM_STAGES];
  logic               ready_c [0:NUM_STAGES];
  hcc_work_t          work_c  [0:NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order <= ORDER_RESET;
    end else if (cfg_we) begin
      grid_order <= cfg_data;
    end
  end

  assign eff_order = (grid_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : grid_order;

  always_comb begin
    entry.op = in_word.op;
    entry.grid_order = eff_order;
    entry.swp = 1'b0;
    entry.inv = 1'b0;
    entry.x_coord = in_word.x_coord;
    entry.y_coord = in_word.y_coord;
    entry.curve_index = in_word.curve_index;
    entry.index_result = '0;
    entry.x_result = '0;
    entry.y_result = '0;
  end

  assign valid_c[0] = in_valid;
  assign work_c[0] = entry;
  assign in_ready = ready_c[0];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    hcc_stage #(
      .FIRST_LEVEL(MAX_ORDER - 1 - k * STAGE_LEVELS),
      .LEVELS     (STAGE_LEVELS)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .up_valid(valid_c[k]),
      .up_ready(ready_c[k]),
      .up_work (work_c[k]),
      .dn_valid(valid_c[k+1]),
      .dn_ready(ready_c[k+1]),
      .dn_work (work_c[k+1])
    );
  end

  assign ready_c[NUM_STAGES] = out_ready;
  assign out_valid = valid_c[NUM_STAGES];
  assign out_word.index_result = work_c[NUM_STAGES].index_result;
  assign out_word.x_result = work_c[NUM_STAGES].x_result;
  assign out_word.y_result = work_c[NUM_STAGES].y_result;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Hilbert curve coordinate and curve index converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hcc_pkg::*;

  localparam int PLAN_LEN = 6;
  localparam int PLAN_ORDER [PLAN_LEN] = '{1, 0, 31, 17, 8, 16};
  localparam int PLAN_COUNT [PLAN_LEN] = '{80, 40, 60, 40, 100, 60};
  localparam int SPLIT_ORDER = 8;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  hcc_in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hcc_out_t out_word;
  logic cfg_we = 1'b0;
  logic [ORDER_W-1:0] cfg_data = '0;

  hcc_in_t pending_words[$];
  hcc_out_t expected_words[$];
  logic [ORDER_W-1:0] order_shadow = ORDER_RESET;
  int mismatch_count = 0;

  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_gap = 0;
  int unsigned recv_calm = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;

  hilbert_curve_convert i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned effective_order(logic [ORDER_W-1:0] order_reg);
    return (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
  endfunction

  function automatic hcc_out_t hilbert_map(logic [ORDER_W-1:0] order_reg, hcc_in_t w);
    int unsigned ord;
    logic [COORD_W-1:0] m;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] t;
    logic [INDEX_W-1:0] d;
    logic qx;
    logic qy;
    hcc_out_t r;
    ord = effective_order(order_reg);
    r = '0;
    if (w.op == OP_TO_INDEX) begin
      m = COORD_W'((32'd1 << ord) - 32'd1);
      x = w.x_coord & m;
      y = w.y_coord & m;
      d = '0;
      for (int lvl = ord; lvl > 0; lvl--) begin
        qx = x[lvl-1];
        qy = y[lvl-1];
        d = d | (INDEX_W'({qx, qx ^ qy}) << (2 * (lvl - 1)));
        if (!qy) begin
          if (qx) begin
            x = m - x;
            y = m - y;
          end
          t = x;
          x = y;
          y = t;
        end
      end
      r.index_result = d;
    end else begin
      d = w.curve_index & INDEX_W'((64'd1 << (2 * ord)) - 64'd1);
      x = '0;
      y = '0;
      for (int lvl = 0; lvl < ord; lvl++) begin
        qx = d[1];
        qy = d[0] ^ qx;
        m = COORD_W'((32'd1 << lvl) - 32'd1);
        if (!qy) begin
          if (qx) begin
            x = m - x;
            y = m - y;
          end
          t = x;
          x = y;
          y = t;
        end
        x = x | (COORD_W'(qx) << lvl);
        y = y | (COORD_W'(qy) << lvl);
        d = d >> 2;
      end
      r.x_result = x;
      r.y_result = y;
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic hcc_in_t random_word(int unsigned ord);
    hcc_in_t w;
    int unsigned sel;
    logic [COORD_W-1:0] cm;
    logic [INDEX_W-1:0] im;
    cm = COORD_W'((32'd1 << ord) - 32'd1);
    im = INDEX_W'((64'd1 << (2 * ord)) - 64'd1);
    w.op = hcc_op_t'($urandom_range(0, 1));
    w.x_coord = COORD_W'($urandom);
    w.y_coord = COORD_W'($urandom);
    w.curve_index = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      w.x_coord = w.x_coord & cm;
      w.y_coord = w.y_coord & cm;
      w.curve_index = w.curve_index & im;
    end else if (sel == 6) begin
      w.x_coord = $urandom_range(0, 1) ? cm : '0;
      w.y_coord = $urandom_range(0, 1) ? cm : '0;
      w.curve_index = $urandom_range(0, 1) ? im : '0;
    end
    return w;
  endfunction

  task automatic push_word(hcc_op_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [INDEX_W-1:0] idx);
    hcc_in_t w;
    w.op = op;
    w.x_coord = x;
    w.y_coord = y;
    w.curve_index = idx;
    pending_words.push_back(w);
  endtask

  task automatic push_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      pending_words.push_back(random_word(effective_order(order_shadow)));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_order(logic [ORDER_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_shadow = value;
  endtask

  // Sender: one word at a time from the pending queue, with random gaps between words.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(hilbert_map(order_shadow, in_word));
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_valid <= 1'b1;
        in_word <= pending_words.pop_front();
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = gap_len();
          if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(10, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each word against the oldest expectation, stalls at random and after results 150 and 700.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word);
          mismatch_count++;
        end else begin
          if (out_word.index_result != expected_words[0].index_result) begin
            $display("%0t: index_result expected %h actual %h", $time,
                     expected_words[0].index_result, out_word.index_result);
            mismatch_count++;
          end
          if (out_word.x_result != expected_words[0].x_result) begin
            $display("%0t: x_result expected %h actual %h", $time,
                     expected_words[0].x_result, out_word.x_result);
            mismatch_count++;
          end
          if (out_word.y_result != expected_words[0].y_result) begin
            $display("%0t: y_result expected %h actual %h", $time,
                     expected_words[0].y_result, out_word.y_result);
            mismatch_count++;
          end
          void'(expected_words.pop_front());
        end
        results_seen++;
        if (results_seen == 150 || results_seen == 700) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if ($urandom_range(0, 3) == 0) begin
          recv_gap = gap_len();
          if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("hilbert_curve_convert: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_word(OP_TO_INDEX, 16'h0000, 16'h0000, 32'h0000_0000);
    push_word(OP_TO_INDEX, 16'hffff, 16'hffff, 32'hffff_ffff);
    push_word(OP_TO_INDEX, 16'hffff, 16'h0000, 32'h0000_0000);
    push_word(OP_TO_INDEX, 16'h0000, 16'hffff, 32'h1234_5678);
    push_word(OP_TO_INDEX, 16'h0001, 16'h0000, 32'h0000_0000);
    push_word(OP_TO_INDEX, 16'h0000, 16'h0001, 32'h0000_0000);
    push_word(OP_TO_INDEX, 16'h0001, 16'h0001, 32'h0000_0000);
    push_word(OP_TO_INDEX, 16'h8000, 16'h7fff, 32'h0000_0000);
    push_word(OP_TO_INDEX, 16'h7fff, 16'h8000, 32'h0000_0000);
    push_word(OP_TO_INDEX, 16'haaaa, 16'h5555, 32'h0000_0000);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'h0000_0000);
    push_word(OP_TO_COORD, 16'hffff, 16'hffff, 32'hffff_ffff);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'h0000_0001);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'h0000_0002);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'h0000_0003);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'h8000_0000);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'h4000_0000);
    push_word(OP_TO_COORD, 16'h1234, 16'hfedc, 32'h5555_5555);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'haaaa_aaaa);
    push_word(OP_TO_COORD, 16'h0000, 16'h0000, 32'h7fff_ffff);
    wait_drained();
    push_random(300);

    for (int p = 0; p < PLAN_LEN; p++) begin
      set_order(ORDER_W'(PLAN_ORDER[p]));
      if (PLAN_ORDER[p] == SPLIT_ORDER) begin
        push_random(PLAN_COUNT[p] / 2);
        wait_drained();
        push_random(PLAN_COUNT[p] / 2);
      end else begin
        push_random(PLAN_COUNT[p]);
      end
    end
    for (int p = 0; p < 4; p++) begin
      set_order(ORDER_W'($urandom_range(0, 31)));
      push_random(70);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("hilbert_curve_convert: match");
    end else begin
      $display("hilbert_curve_convert: mismatch");
    end
    $finish;
  end

endmodule
